### rtl/mst_pkg.sv
// ---------------------------------------------------------------------------
// mst_pkg - shared definitions for the multiset table engine
// Action and status codes, sequencer states and parameter defaults.
// ---------------------------------------------------------------------------
package mst_pkg;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // fixed field widths of the request and result words
    localparam int ACTION_W = 3;
    localparam int ITEM_W   = 32;
    localparam int MATCH_W  = 6;
    localparam int FILL_W   = 6;
    localparam int STATUS_W = 2;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ERASE_ALL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE_ONE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_COUNT     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FILL      = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SWAP,
        S_DONE
    } mst_state_t;

endpackage

### rtl/mst_store.sv
// ---------------------------------------------------------------------------
// mst_store - element store
// Single write port, single read port RAM with a registered read word
// (valid in the cycle after the read). Contents are undefined until written.
// ---------------------------------------------------------------------------
module mst_store
    import mst_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and read the array, read word registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/multiset_table_engine.sv
// ---------------------------------------------------------------------------
// multiset_table_engine - unordered multiset kept in a RAM with a fill count
// Insert appends at the end; erase moves the last element into the freed
// slot (erase all examines that slot again); count walks all stored elements.
// ---------------------------------------------------------------------------
// Insert, fill query and refused requests go straight to the result stage;
// erase and count walk the slots through the read and check states, with a swap
// state for each removal (erase all checks a slot again after each swap).
// One request at a time: the input stalls until the result word is loaded.
// Reset clears the fill count and control; the store is not cleared.
module multiset_table_engine
    import mst_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic signed [ITEM_W-1:0] item_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [MATCH_W-1:0]  match_count,
    output logic                removed,
    output logic [FILL_W-1:0]   fill_level,
    output logic [STATUS_W-1:0] status
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    mst_state_t state_reg, state_next;

    logic [ACTION_W-1:0]    act_reg, act_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          match_reg, match_next;
    logic                   removed_reg, removed_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic                   out_valid_reg, out_valid_next;
    logic [MATCH_W-1:0]     out_match_reg, out_match_next;
    logic                   out_removed_reg, out_removed_next;
    logic [FILL_W-1:0]      out_fill_reg, out_fill_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;

    logic                   in_accept;
    logic                   out_free;
    logic                   table_full;
    logic                   table_empty;
    logic                   walk_end;
    logic                   hit;
    logic [63:0]            item_ext;
    logic [VALUE_WIDTH-1:0] item_norm;
    logic [CW-1:0]          last_idx;
    logic [CW+MATCH_W-1:0]  match_wide;
    logic [CW+FILL_W-1:0]   fill_wide;

    // element store
    mst_store #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake and status decode
    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign table_full  = (count_reg >= FULL_COUNT);
    assign table_empty = (count_reg == '0);
    assign walk_end    = (idx_reg >= count_reg);
    assign hit         = (rd_data == val_reg);
    assign last_idx    = count_reg - CW'(1);

    // sign-extend the value word, then cut to the stored width
    assign item_ext  = {{(64 - ITEM_W){item_value[ITEM_W-1]}}, item_value};
    assign item_norm = item_ext[VALUE_WIDTH-1:0];

    // fit internal counts to the result field widths
    assign match_wide = {{MATCH_W{1'b0}}, match_reg};
    assign fill_wide  = {{FILL_W{1'b0}}, count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if ((action == ACT_ERASE_ALL || action == ACT_ERASE_ONE ||
                         action == ACT_COUNT) && !table_empty)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                state_next = walk_end ? S_DONE : S_CHECK;
            end
            S_CHECK:
            begin
                if (hit && act_reg != ACT_COUNT)
                begin
                    state_next = S_SWAP;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_SWAP:
            begin
                state_next = (act_reg == ACT_ERASE_ONE) ? S_DONE : S_READ;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, store access and result word
    always_comb
    begin
        act_next         = act_reg;
        val_next         = val_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        match_next       = match_reg;
        removed_next     = removed_reg;
        status_next      = status_reg;
        out_match_next   = out_match_reg;
        out_removed_next = out_removed_reg;
        out_fill_next    = out_fill_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        wr_en            = 1'b0;
        wr_addr          = count_reg[IW-1:0];
        wr_data          = item_norm;
        rd_en            = 1'b0;
        rd_addr          = idx_reg[IW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                // latch the request; append or refuse on the spot
                if (in_accept)
                begin
                    act_next     = action;
                    val_next     = item_norm;
                    idx_next     = '0;
                    match_next   = '0;
                    removed_next = 1'b0;
                    status_next  = STAT_OK;
                    case (action)
                        ACT_INSERT:
                        begin
                            if (table_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_ERASE_ALL, ACT_ERASE_ONE, ACT_COUNT:
                        begin
                            if (table_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // fetch the slot under examination
                rd_en = !walk_end;
            end
            S_CHECK:
            begin
                // count and step, or fetch the last element for a swap
                if (hit && act_reg != ACT_COUNT)
                begin
                    rd_en   = 1'b1;
                    rd_addr = last_idx[IW-1:0];
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    if (hit)
                    begin
                        match_next = match_reg + CW'(1);
                    end
                end
            end
            S_SWAP:
            begin
                // move the last element into the freed slot, shrink the table
                wr_en      = 1'b1;
                wr_addr    = idx_reg[IW-1:0];
                wr_data    = rd_data;
                count_next = last_idx;
                if (act_reg == ACT_ERASE_ONE)
                begin
                    removed_next = 1'b1;
                end
                else
                begin
                    match_next = match_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                // load the result word once the output register is free
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_match_next   = match_wide[MATCH_W-1:0];
                    out_removed_next = removed_reg;
                    out_fill_next    = fill_wide[FILL_W-1:0];
                    out_status_next  = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        val_reg         <= val_next;
        idx_reg         <= idx_next;
        match_reg       <= match_next;
        removed_reg     <= removed_next;
        status_reg      <= status_next;
        out_match_reg   <= out_match_next;
        out_removed_reg <= out_removed_next;
        out_fill_reg    <= out_fill_next;
        out_status_reg  <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign match_count = out_match_reg;
    assign removed     = out_removed_reg;
    assign fill_level  = out_fill_reg;
    assign status      = out_status_reg;

endmodule

### rtl/mst_checker.sv
// ---------------------------------------------------------------------------
// mst_checker - port-level checks for the multiset table engine
// Watches the request and result channels and flags inconsistent words.
// ---------------------------------------------------------------------------
module mst_checker
    import mst_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [MATCH_W-1:0]  match_count,
    input logic                removed,
    input logic [FILL_W-1:0]   fill_level,
    input logic [STATUS_W-1:0] status
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(match_count) &&
        $stable(removed) && $stable(fill_level) && $stable(status))
        else $error("stalled result word changed");

    // busy right after taking a request word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while previous one still in work");

    // refused on empty table: nothing matched, nothing stored
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |->
        fill_level == '0 && match_count == '0 && !removed)
        else $error("empty refusal with nonzero fields");

    // single removal reports no count and ok status
    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && removed |-> match_count == '0 && status == STAT_OK)
        else $error("removed flag with inconsistent fields");

endmodule

bind multiset_table_engine mst_checker u_mst_checker (.*);

### bench/tb_multiset_table_engine.sv
// ---------------------------------------------------------------------------
// tb_multiset_table_engine - self-checking bench for the multiset table engine
// Feeds request words through a valid/stall driver, tracks the bag contents
// and fill count in a local model, and checks every result word field by
// field in order. Random idling on both sides, one long output hold-off.
// ---------------------------------------------------------------------------
module tb_multiset_table_engine;
    import mst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int VW           = DEF_VALUE_WIDTH;
    localparam int RANDOM_WORDS = 1850;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AT      = 4000;
    localparam int HOLD_LEN     = 600;
    localparam int STEADY_LO    = 5000;
    localparam int STEADY_HI    = 8000;
    localparam int DRAIN_WAIT   = 200;

    // action codes the block ignores
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [ITEM_W-1:0]   val;
    } request_t;

    typedef struct packed {
        logic [MATCH_W-1:0]  copies;
        logic                hit;
        logic [FILL_W-1:0]   fill;
        logic [STATUS_W-1:0] stat;
    } result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [ACTION_W-1:0]      action = ACT_FILL;
    logic signed [ITEM_W-1:0] item_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [MATCH_W-1:0]       match_count;
    logic                     removed;
    logic [FILL_W-1:0]        fill_level;
    logic [STATUS_W-1:0]      status;

    request_t pending_words[$];
    result_t  expected_results[$];
    logic     word_taken = 1'b0;
    int       cyc = 0;
    int       hold_left = 0;
    int       errors = 0;

    // local copy of the bag
    logic [VW-1:0] bag_store [DEPTH];
    int            bag_fill = 0;

    multiset_table_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_count (match_count),
        .removed     (removed),
        .fill_level  (fill_level),
        .status      (status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one request to the bag and return the result it should give
    function automatic result_t bag_apply(request_t req);
        logic [VW-1:0] key;
        int            i;
        result_t       r;
        key = req.val[VW-1:0];
        r   = '0;
        case (req.act)
            ACT_INSERT:
            begin
                if (bag_fill >= DEPTH)
                    r.stat = STAT_FULL;
                else
                begin
                    bag_store[bag_fill] = key;
                    bag_fill++;
                end
            end
            ACT_ERASE_ALL:
            begin
                if (bag_fill == 0)
                    r.stat = STAT_EMPTY;
                else
                begin
                    // swap the last entry in and look at the same slot again
                    i = 0;
                    while (i < bag_fill)
                    begin
                        if (bag_store[i] == key)
                        begin
                            bag_store[i] = bag_store[bag_fill-1];
                            bag_fill--;
                            r.copies = r.copies + MATCH_W'(1);
                        end
                        else
                            i++;
                    end
                end
            end
            ACT_ERASE_ONE:
            begin
                if (bag_fill == 0)
                    r.stat = STAT_EMPTY;
                else
                begin
                    for (i = 0; i < bag_fill; i++)
                    begin
                        if (bag_store[i] == key)
                        begin
                            bag_store[i] = bag_store[bag_fill-1];
                            bag_fill--;
                            r.hit = 1'b1;
                            break;
                        end
                    end
                end
            end
            ACT_COUNT:
            begin
                if (bag_fill == 0)
                    r.stat = STAT_EMPTY;
                else
                    for (i = 0; i < bag_fill; i++)
                        if (bag_store[i] == key)
                            r.copies = r.copies + MATCH_W'(1);
            end
            default: ;
        endcase
        r.fill = bag_fill[FILL_W-1:0];
        return r;
    endfunction

    // idle with a chance of about 22 in 100, never inside the steady window
    function automatic logic take_gap();
        if (cyc >= STEADY_LO && cyc < STEADY_HI)
            return 1'b0;
        return $urandom_range(99) < 22;
    endfunction

    task automatic push_word(logic [ACTION_W-1:0] act, logic [ITEM_W-1:0] val);
        request_t w;
        w.act = act;
        w.val = val;
        pending_words.push_back(w);
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // corners: empty refusals, extreme values, misses, spare codes
    task automatic build_directed_words();
        push_word(ACT_FILL, 32'h0);
        push_word(ACT_COUNT, 32'h0);
        push_word(ACT_ERASE_ALL, 32'h0);
        push_word(ACT_ERASE_ONE, 32'hFFFF_FFFF);
        push_word(ACT_INSERT, 32'h8000_0000);
        push_word(ACT_INSERT, 32'h7FFF_FFFF);
        push_word(ACT_INSERT, 32'h0000_0000);
        push_word(ACT_INSERT, 32'hFFFF_FFFF);
        push_word(ACT_INSERT, 32'h7FFF_FFFF);
        push_word(ACT_INSERT, 32'h8000_0000);
        push_word(ACT_COUNT, 32'h7FFF_FFFF);
        push_word(ACT_COUNT, 32'h1234_5678);
        push_word(ACT_ERASE_ONE, 32'h0000_0005);
        push_word(ACT_ERASE_ONE, 32'h8000_0000);
        push_word(ACT_ERASE_ALL, 32'h7FFF_FFFF);
        push_word(ACT_FILL, 32'hA5A5_A5A5);
        push_word(ACT_SPARE_LO, 32'h0000_0000);
        push_word(ACT_SPARE_LO + 3'd1, 32'hFFFF_FFFF);
        push_word(ACT_SPARE_HI, 32'h8000_0000);
        push_word(ACT_ERASE_ALL, 32'h0000_0000);
        push_word(ACT_ERASE_ALL, 32'hFFFF_FFFF);
        push_word(ACT_ERASE_ALL, 32'h8000_0000);
        push_word(ACT_ERASE_ONE, 32'h0000_0000);
        push_word(ACT_COUNT, 32'h8000_0000);
        push_word(ACT_FILL, 32'h5A5A_5A5A);
    endtask

    // random blocks that lean toward filling, draining or a mix
    task automatic build_random_words();
        int                  counted;
        int                  block_left;
        int                  pool_n;
        int                  pick;
        int                  t_ins, t_one, t_all, t_cnt;
        logic [ITEM_W-1:0]   pool [6];
        logic [ITEM_W-1:0]   val;
        logic [ACTION_W-1:0] act;
        counted    = 0;
        block_left = 0;
        pool_n     = 1;
        t_ins = 0; t_one = 0; t_all = 0; t_cnt = 0;
        while (counted < RANDOM_WORDS)
        begin
            if (block_left == 0)
            begin
                block_left = $urandom_range(80, 30);
                case ($urandom_range(2))
                    0: begin t_ins = 80; t_one = 86; t_all = 89; t_cnt = 95; end
                    1: begin t_ins = 20; t_one = 45; t_all = 65; t_cnt = 92; end
                    default: begin t_ins = 45; t_one = 60; t_all = 70; t_cnt = 90; end
                endcase
                // small value pool so copies pile up
                pool_n = $urandom_range(6, 1);
                for (int k = 0; k < 6; k++)
                begin
                    case ($urandom_range(7))
                        0: pool[k] = 32'h8000_0000;
                        1: pool[k] = 32'h7FFF_FFFF;
                        2: pool[k] = 32'h0000_0000;
                        3: pool[k] = 32'hFFFF_FFFF;
                        default: pool[k] = $urandom;
                    endcase
                end
            end
            pick = $urandom_range(99);
            if (pick < t_ins)
                act = ACT_INSERT;
            else if (pick < t_one)
                act = ACT_ERASE_ONE;
            else if (pick < t_all)
                act = ACT_ERASE_ALL;
            else if (pick < t_cnt)
                act = ACT_COUNT;
            else if (pick < 98)
                act = ACT_FILL;
            else
                act = ACTION_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
            if ($urandom_range(99) < 75)
                val = pool[$urandom_range(pool_n - 1)];
            else
                val = $urandom;
            push_word(act, val);
            if (act < ACT_SPARE_LO)
                counted++;
            block_left--;
        end
    endtask

    // count cycles and stop a hung run
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("tb_multiset_table_engine: FAIL");
            $finish;
        end
    end

    // note accepted request words and predict their results
    always @(posedge clk)
    begin : accept_words
        request_t w;
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            word_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                w.act = action;
                w.val = item_value;
                expected_results.push_back(bag_apply(w));
            end
        end
    end

    // drive request words at the falling edge; hold while stalled
    always @(negedge clk)
    begin : drive_words
        request_t nxt;
        if (rst_n && (!in_valid || word_taken))
        begin
            if (pending_words.size() != 0 && !take_gap())
            begin
                nxt = pending_words.pop_front();
                action     <= nxt.act;
                item_value <= nxt.val;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // stall results at random, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (cyc == HOLD_AT)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
        end
        else
            out_stall <= take_gap();
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin : check_words
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with no prediction, expected none, actual %0d/%0d/%0d/%0d",
                         $time, match_count, removed, fill_level, status);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("match_count", 32'(e.copies), 32'(match_count));
                check_field("removed", 32'(e.hit), 32'(removed));
                check_field("fill_level", 32'(e.fill), 32'(fill_level));
                check_field("status", 32'(e.stat), 32'(status));
            end
        end
    end

    // load stimulus, release reset, drain and report
    initial
    begin
        build_directed_words();
        build_random_words();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_multiset_table_engine: PASS");
        else
            $display("tb_multiset_table_engine: FAIL");
        $finish;
    end

endmodule
